### hw/rtl/cbz_pkg.sv
// Package for the cubic Bezier sub-segment core: field widths, word structs.
// No dependencies.
package cbz_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned TFrac  = 16;
  localparam int unsigned TW     = TFrac + 1;
  localparam int unsigned PtN    = 8;
  localparam logic [TW-1:0] TOne = TW'(1) << TFrac;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [TW-1:0] tpar_t;

  typedef struct packed {
    coord_t ctrl0_x; coord_t ctrl0_y;
    coord_t ctrl1_x; coord_t ctrl1_y;
    coord_t ctrl2_x; coord_t ctrl2_y;
    coord_t ctrl3_x; coord_t ctrl3_y;
    tpar_t  t_start; tpar_t  t_end;
  } cbz_in_t;

  typedef struct packed {
    coord_t seg0_x; coord_t seg0_y;
    coord_t seg1_x; coord_t seg1_y;
    coord_t seg2_x; coord_t seg2_y;
    coord_t seg3_x; coord_t seg3_y;
  } cbz_out_t;

  // Lerp step: a + floor((b - a) * t / 2^TFrac); the result stays between a and b for t up to 1.0.
  function automatic coord_t lerp(coord_t a, coord_t b, tpar_t t);
    logic signed [CoordW:0] diff;
    logic signed [CoordW+TW+1:0] prod;
    diff = {a[CoordW-1], a} - {b[CoordW-1], b};
    diff = -diff;
    prod = diff * $signed({1'b0, t});
    return coord_t'($signed({a[CoordW-1], a}) + (prod >>> TFrac));
  endfunction
endpackage

### hw/rtl/cbz_div.sv
// Pipelined restoring divider: ratio = ((t1-t0) << TFrac) / (1 - t0).
// Depends on cbz_pkg. One quotient bit per stage, TW stages, one item per cycle.
module cbz_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cbz_pkg::tpar_t num_i,
  input  cbz_pkg::tpar_t den_i,
  output cbz_pkg::tpar_t quo_o
);
  import cbz_pkg::*;
  localparam int unsigned NB = TW + TFrac;
  logic [NB-1:0] rem_q [TW+1];
  tpar_t         den_q [TW+1];
  tpar_t         quo_q [TW+1];
  logic          unused;
  assign unused = rst_ni;
  always_comb begin
    rem_q[0] = NB'(num_i) << TFrac;
    den_q[0] = den_i;
    quo_q[0] = '0;
  end
  // Quotient fits TW bits since num <= den; the dividend carries num scaled by 2^TFrac.
  for (genvar s = 0; s < TW; s++) begin : g_st
    logic [NB:0] trial;
    logic [NB-1:0] rem_d;
    always_comb begin
      trial = {1'b0, rem_q[s]} - ({(NB+1)'(den_q[s])} << (TW - 1 - s));
      rem_d = trial[NB] ? rem_q[s] : trial[NB-1:0];
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      den_q[s+1] <= den_q[s];
      quo_q[s+1] <= {quo_q[s][TW-2:0], ~trial[NB]};
    end
  end
  assign quo_o = quo_q[TW];
endmodule

### hw/rtl/cbz_split.sv
// Three-stage de Casteljau split of one coordinate of four points.
// Depends on cbz_pkg. Each stage registers one lerp level.
module cbz_split (
  input  logic            clk_i,
  input  cbz_pkg::coord_t p_i [4],
  input  cbz_pkg::tpar_t  t_i,
  output cbz_pkg::coord_t l_o [4],
  output cbz_pkg::coord_t r_o [4]
);
  import cbz_pkg::*;
  coord_t p0_q, p3_q, a_q, b_q, c_q, p0b_q, p3b_q, a2_q, c2_q, ab_q, bc_q;
  coord_t p0c_q, p3c_q, a3_q, c3_q, ab3_q, bc3_q, m_q;
  tpar_t  t1_q, t2_q;
  always_ff @(posedge clk_i) begin
    a_q <= lerp(p_i[0], p_i[1], t_i);
    b_q <= lerp(p_i[1], p_i[2], t_i);
    c_q <= lerp(p_i[2], p_i[3], t_i);
    p0_q <= p_i[0]; p3_q <= p_i[3]; t1_q <= t_i;
    ab_q <= lerp(a_q, b_q, t1_q);
    bc_q <= lerp(b_q, c_q, t1_q);
    p0b_q <= p0_q; p3b_q <= p3_q; a2_q <= a_q; c2_q <= c_q; t2_q <= t1_q;
    m_q <= lerp(ab_q, bc_q, t2_q);
    p0c_q <= p0b_q; p3c_q <= p3b_q; a3_q <= a2_q; c3_q <= c2_q;
    ab3_q <= ab_q; bc3_q <= bc_q;
  end
  assign l_o = '{p0c_q, a3_q, ab3_q, m_q};
  assign r_o = '{m_q, bc3_q, c3_q, p3c_q};
endmodule

### hw/rtl/cubic_bezier_segment_extract_core.sv
// Top level of the cubic Bezier sub-segment core.
// Depends on cbz_pkg, cbz_split and cbz_div.
//
// One word enters per cycle while start_i is high (busy_o is always low: the
// pipeline never stalls, and the receiver cannot hold results off). Every word
// leaves, in order, with done_o high for one cycle. Each result passes through the
// seventeen-stage ratio divider, one register that lines the ratio up with the
// delayed right half, and the second split (three lerp levels); the first split
// runs alongside the divider.
// t values above 1.0 saturate to 1.0. If t_end <= t_start all four points are
// the curve point at t_start; a split at 0 or 1 passes the points through.
module cubic_bezier_segment_extract_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cbz_pkg::cbz_in_t  in_i,
  output logic              done_o,
  output cbz_pkg::cbz_out_t out_o
);
  import cbz_pkg::*;
  localparam int unsigned L1 = 3;
  localparam int unsigned LD = TW;
  localparam int unsigned LT = LD + 1 + 3;

  typedef struct packed {
    logic  empty;
    logic  full_end;
    tpar_t t0;
  } ctl_t;

  assign busy_o = 1'b0;

  tpar_t t0, t1;
  assign t0 = (in_i.t_start > TOne) ? TOne : in_i.t_start;
  assign t1 = (in_i.t_end > TOne) ? TOne : in_i.t_end;

  // Valid shift line.
  logic [LT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LT-2:0], start_i};
    end
  end
  assign done_o = vld_q[LT-1];

  // First split at t0 (t0 = 0 yields the input points as right half).
  coord_t px [2][4];
  coord_t l1 [2][4];
  coord_t r1 [2][4];
  assign px[0] = '{in_i.ctrl0_x, in_i.ctrl1_x, in_i.ctrl2_x, in_i.ctrl3_x};
  assign px[1] = '{in_i.ctrl0_y, in_i.ctrl1_y, in_i.ctrl2_y, in_i.ctrl3_y};

  // Ratio divider: numerator zero when empty, denominator never zero then.
  tpar_t num, den, ratio;
  assign num = (t1 > t0) ? tpar_t'(t1 - t0) : '0;
  assign den = (t1 > t0) ? tpar_t'(TOne - t0) : TOne;
  cbz_div u_div (.clk_i, .rst_ni, .num_i(num), .den_i(den), .quo_o(ratio));

  // Hold control alongside the first split and the divider.
  ctl_t ctl_q [L1+LD];
  ctl_t ctl_d;
  assign ctl_d = '{empty: (t1 <= t0), full_end: (t1 == TOne), t0: t0};
  always_ff @(posedge clk_i) begin
    ctl_q[0] <= ctl_d;
    for (int i = 1; i < L1 + LD; i++) ctl_q[i] <= ctl_q[i-1];
  end

  // Delay the right half until the ratio is ready.
  coord_t mid_q [LD-L1+1][2][4];
  always_ff @(posedge clk_i) begin
    mid_q[0] <= r1;
    for (int i = 1; i <= LD - L1; i++) mid_q[i] <= mid_q[i-1];
  end

  // The divider output and the delayed right half mid_q[LD-L1] arrive out of step:
  // register the ratio and its control word once more to line them up.
  tpar_t ratio_q;
  ctl_t  ctl2_q;
  always_ff @(posedge clk_i) begin
    ratio_q <= ratio;
    ctl2_q  <= ctl_q[LD-1];
  end

  // Second split; for empty or full_end, force t = 1 so the left half is the input.
  tpar_t t2;
  assign t2 = (ctl2_q.empty || ctl2_q.full_end) ? TOne : ratio_q;
  coord_t l2 [2][4];
  coord_t r2 [2][4];
  logic   emp3_q [3];
  always_ff @(posedge clk_i) begin
    emp3_q[0] <= ctl2_q.empty;
    emp3_q[1] <= emp3_q[0];
    emp3_q[2] <= emp3_q[1];
  end

  for (genvar d = 0; d < 2; d++) begin : g_dim
    cbz_split u_s1 (.clk_i, .p_i(px[d]), .t_i(t0), .l_o(l1[d]), .r_o(r1[d]));
    cbz_split u_s2 (.clk_i, .p_i(mid_q[LD-L1][d]), .t_i(t2), .l_o(l2[d]), .r_o(r2[d]));
  end

  // Empty interval: all points equal the point at t0, which is mid[0].
  coord_t o [2][4];
  always_comb begin
    for (int d = 0; d < 2; d++)
      for (int k = 0; k < 4; k++)
        o[d][k] = emp3_q[2] ? l2[d][0] : l2[d][k];
  end
  assign out_o = '{seg0_x: o[0][0], seg0_y: o[1][0], seg1_x: o[0][1], seg1_y: o[1][1],
                   seg2_x: o[0][2], seg2_y: o[1][2], seg3_x: o[0][3], seg3_y: o[1][3]};

  logic unused;
  assign unused = ^{r2[0][0], r2[1][0], ctl_q[L1+LD-1], ctl2_q.t0, r2[0][1], r2[1][1],
                    r2[0][2], r2[1][2], r2[0][3], r2[1][3], l1[0][0], l1[1][0],
                    l1[0][1], l1[1][1], l1[0][2], l1[1][2], l1[0][3], l1[1][3]};
endmodule

### hw/rtl/cbz_checker.sv
// Port checker for the sub-segment core, with its bind.
// Depends on the top level's ports.
module cbz_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);
  localparam int unsigned Lat = 21;
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat done_o) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat)) else $error("result invented");
endmodule

bind cubic_bezier_segment_extract_core cbz_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o);

### verif/testbench.sv
// Self-checking testbench for cubic_bezier_segment_extract_core: directed table, then random words.
// Depends on cbz_pkg and the core RTL; predicts each sub-segment in fixed point and checks in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbz_pkg::*;

  localparam int unsigned NRand = 1750;
  localparam int unsigned Latency = 21;
  localparam longint CycleLimit = 200000;
  localparam logic [16:0] TMax = 17'h1ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic done_o;
  cbz_in_t in_i = '0;
  cbz_out_t out_o;

  cubic_bezier_segment_extract_core u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .done_o, .out_o
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cbz_out_t segment_q[$];
  int unsigned n_fail = 0;
  longint cycle_cnt = 0;

  // Lerp with floor of the exact product; diff and product widened to avoid overflow.
  function automatic longint lerp_fx(longint a, longint b, longint t);
    logic signed [127:0] prod;
    prod = 128'(signed'(b - a)) * 128'(signed'(t));
    return a + longint'(prod >>> TFrac);
  endfunction

  // One de Casteljau split of one coordinate; returns left and right halves.
  function automatic void split_fx(input longint p[4], input longint t,
                                   output longint lh[4], output longint rh[4]);
    longint a, b, c, ab, bc, m;
    a = lerp_fx(p[0], p[1], t);
    b = lerp_fx(p[1], p[2], t);
    c = lerp_fx(p[2], p[3], t);
    ab = lerp_fx(a, b, t);
    bc = lerp_fx(b, c, t);
    m = lerp_fx(ab, bc, t);
    lh = '{p[0], a, ab, m};
    rh = '{m, bc, c, p[3]};
  endfunction

  function automatic void sub_segment(input longint p[4], input longint t0, input longint t1,
                                      output longint r[4]);
    longint lh[4], rh[4], mid[4];
    longint one, ratio;
    one = longint'(TOne);
    if (t1 <= t0) begin
      split_fx(p, t0, lh, rh);
      r = '{rh[0], rh[0], rh[0], rh[0]};
      return;
    end
    mid = p;
    if (t0 > 0) begin
      split_fx(p, t0, lh, rh);
      mid = rh;
    end
    r = mid;
    if (t1 < one) begin
      ratio = ((t1 - t0) * one) / (one - t0);
      split_fx(mid, ratio, lh, rh);
      r = lh;
    end
  endfunction

  function automatic cbz_out_t predict_segment(cbz_in_t w);
    longint px[4], py[4], rx[4], ry[4];
    longint t0, t1;
    cbz_out_t o;
    px = '{longint'(w.ctrl0_x), longint'(w.ctrl1_x), longint'(w.ctrl2_x), longint'(w.ctrl3_x)};
    py = '{longint'(w.ctrl0_y), longint'(w.ctrl1_y), longint'(w.ctrl2_y), longint'(w.ctrl3_y)};
    // Saturate parameters above one.
    t0 = (w.t_start > TOne) ? longint'(TOne) : longint'(w.t_start);
    t1 = (w.t_end > TOne) ? longint'(TOne) : longint'(w.t_end);
    sub_segment(px, t0, t1, rx);
    sub_segment(py, t0, t1, ry);
    o.seg0_x = coord_t'(rx[0]); o.seg0_y = coord_t'(ry[0]);
    o.seg1_x = coord_t'(rx[1]); o.seg1_y = coord_t'(ry[1]);
    o.seg2_x = coord_t'(rx[2]); o.seg2_y = coord_t'(ry[2]);
    o.seg3_x = coord_t'(rx[3]); o.seg3_y = coord_t'(ry[3]);
    return o;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(32'h8000_0000);
      1: return coord_t'(32'h7fff_ffff);
      2: return coord_t'($signed($urandom_range(0, 4095)) - 2048);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic tpar_t rand_t();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TOne;
      2: return tpar_t'($urandom_range(65537, 131071));
      3: return tpar_t'($urandom());
      default: return tpar_t'($urandom_range(0, 65536));
    endcase
  endfunction

  // Directed rows; has_gold marks rows whose result is typed in.
  typedef struct {
    cbz_in_t word;
    bit has_gold;
    cbz_out_t gold;
  } stim_row_t;
  stim_row_t stim_tbl[$];

  function automatic cbz_in_t make_word(coord_t v0, coord_t v1, coord_t v2, coord_t v3,
                                        tpar_t ts, tpar_t te);
    cbz_in_t w;
    w.ctrl0_x = v0; w.ctrl0_y = v3; w.ctrl1_x = v1; w.ctrl1_y = v2;
    w.ctrl2_x = v2; w.ctrl2_y = v1; w.ctrl3_x = v3; w.ctrl3_y = v0;
    w.t_start = ts; w.t_end = te;
    return w;
  endfunction

  function automatic cbz_out_t as_out(cbz_in_t w);
    cbz_out_t o;
    o.seg0_x = w.ctrl0_x; o.seg0_y = w.ctrl0_y; o.seg1_x = w.ctrl1_x; o.seg1_y = w.ctrl1_y;
    o.seg2_x = w.ctrl2_x; o.seg2_y = w.ctrl2_y; o.seg3_x = w.ctrl3_x; o.seg3_y = w.ctrl3_y;
    return o;
  endfunction

  task automatic add_row(cbz_in_t w, bit gold_known, cbz_out_t g);
    stim_row_t r;
    r.word = w; r.has_gold = gold_known; r.gold = g;
    stim_tbl.push_back(r);
  endtask

  task automatic build_table();
    coord_t mn, mx;
    cbz_in_t w;
    cbz_out_t g;
    mn = coord_t'(32'h8000_0000);
    mx = coord_t'(32'h7fff_ffff);
    // Whole curve: points pass through unchanged.
    w = make_word(mn, mx, mn, mx, '0, TOne);
    add_row(w, 1'b1, as_out(w));
    w = make_word(mx, mn, mx, mn, '0, TMax);
    add_row(w, 1'b1, as_out(w));
    w = make_word(32'sd100, -32'sd7, 32'sd0, 32'sd1, '0, TOne);
    add_row(w, 1'b1, as_out(w));
    // Empty interval at t = 0: all points are the start point.
    w = make_word(mx, mn, 32'sd5, mn, '0, '0);
    g = '{mx, mn, mx, mn, mx, mn, mx, mn};
    add_row(w, 1'b1, g);
    // Empty interval at t = 1 (saturated): all points are the end point.
    w = make_word(mn, mx, mx, mx, TMax, TMax);
    g = '{mx, mn, mx, mn, mx, mn, mx, mn};
    add_row(w, 1'b1, g);
    w = make_word(32'sd9, 32'sd3, 32'sd3, -32'sd4, TOne, 17'd1000);
    g = '{-32'sd4, 32'sd9, -32'sd4, 32'sd9, -32'sd4, 32'sd9, -32'sd4, 32'sd9};
    add_row(w, 1'b1, g);
    // Predictor rows: halves, reversed, tiny intervals, saturation, extremes.
    add_row(make_word(mn, mx, mn, mx, 17'd32768, TOne), 1'b0, g);
    add_row(make_word(mn, mx, mn, mx, '0, 17'd32768), 1'b0, g);
    add_row(make_word(mn, mx, mn, mx, 17'd16384, 17'd49152), 1'b0, g);
    add_row(make_word(mx, mn, mx, mn, 17'd49152, 17'd16384), 1'b0, g);
    add_row(make_word(mx, mn, mn, mx, 17'd65535, TOne), 1'b0, g);
    add_row(make_word(mx, mn, mn, mx, 17'd1, 17'd2), 1'b0, g);
    add_row(make_word(mx, mn, mn, mx, 17'd65534, 17'd65535), 1'b0, g);
    add_row(make_word(-32'sd1, 32'sd1, -32'sd1, 32'sd1, 17'd70000, 17'd1), 1'b0, g);
    add_row(make_word(32'sd256, -32'sd256, 32'sd512, 32'sd0, 17'd1, TMax), 1'b0, g);
    add_row(make_word(mn, mn, mx, mx, 17'd12345, 17'd54321), 1'b0, g);
    add_row(make_word(32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'h1aaaa, 17'h15555), 1'b0, g);
  endtask

  function automatic void check_field(string name, coord_t exp_v, coord_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  // Compare each done word with the oldest pending segment.
  always @(posedge clk_i) begin
    cbz_out_t e;
    if (rst_ni && done_o) begin
      if (segment_q.size() == 0) begin
        $error("unexpected result word");
        n_fail++;
      end else begin
        e = segment_q.pop_front();
        check_field("seg0_x", e.seg0_x, out_o.seg0_x);
        check_field("seg0_y", e.seg0_y, out_o.seg0_y);
        check_field("seg1_x", e.seg1_x, out_o.seg1_x);
        check_field("seg1_y", e.seg1_y, out_o.seg1_y);
        check_field("seg2_x", e.seg2_x, out_o.seg2_x);
        check_field("seg2_y", e.seg2_y, out_o.seg2_y);
        check_field("seg3_x", e.seg3_x, out_o.seg3_x);
        check_field("seg3_y", e.seg3_y, out_o.seg3_y);
      end
    end
  end

  // Watchdog: fail when the run overshoots its cycle budget.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("cubic_bezier_segment_extract_core: mismatch");
      $finish;
    end
  end

  // Present one word from the falling edge; drop start only while idling.
  task automatic send_word(cbz_in_t w, cbz_out_t exp_seg);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    segment_q.push_back(exp_seg);
    @(negedge clk_i);
  endtask

  initial begin
    cbz_in_t w;
    cbz_out_t e;
    build_table();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: typed gold where known, predictor otherwise.
    foreach (stim_tbl[i]) begin
      e = stim_tbl[i].has_gold ? stim_tbl[i].gold : predict_segment(stim_tbl[i].word);
      send_word(stim_tbl[i].word, e);
    end

    for (int unsigned n = 0; n < NRand; n++) begin
      // Hold off once mid-run until the pipeline drains.
      if (n == NRand / 2) begin
        start_i <= 1'b0;
        while (segment_q.size() != 0) @(negedge clk_i);
      end
      w.ctrl0_x = rand_coord(); w.ctrl0_y = rand_coord();
      w.ctrl1_x = rand_coord(); w.ctrl1_y = rand_coord();
      w.ctrl2_x = rand_coord(); w.ctrl2_y = rand_coord();
      w.ctrl3_x = rand_coord(); w.ctrl3_y = rand_coord();
      w.t_start = rand_t();
      w.t_end = rand_t();
      send_word(w, predict_segment(w));
    end

    start_i <= 1'b0;
    while (segment_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("cubic_bezier_segment_extract_core: match");
    end else begin
      $display("cubic_bezier_segment_extract_core: mismatch");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/cbz_pkg.sv
hw/rtl/cbz_div.sv
hw/rtl/cbz_split.sv
hw/rtl/cubic_bezier_segment_extract_core.sv
hw/rtl/cbz_checker.sv
verif/testbench.sv
